### hw/rtl/round_robin_slice_scheduler_defines.svh
// Assertion macros for the round-robin slice scheduler.
// Uses clk_i and rst_ni of the module that expands them.
`ifndef ROUND_ROBIN_SLICE_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_SLICE_SCHEDULER_DEFINES_SVH
`ifndef SYNTH
`define RRSS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
`define RRSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RRSS_ASSERT(lbl, cond, msg)
`define RRSS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/rrss_pkg.sv
// Shared widths, codes and controller/datapath types of the slice scheduler.
// No dependencies.
package rrss_pkg;

  localparam int unsigned MAX_PROCS_DEF = 16;
  localparam int unsigned DUR_BITS_DEF  = 16;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned IN_W   = 16;
  localparam int unsigned TQ_W   = 16;
  localparam int unsigned TIME_W = 21;
  localparam int unsigned SUM_W  = 25;
  localparam int unsigned PNUM_W = 5;
  localparam int unsigned STAT_W = 2;

  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FN_LOAD  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_SCHED = 2'd2;

  localparam logic [STAT_W-1:0] ST_ACCEPT = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_GRANT  = 2'd2;
  localparam logic [STAT_W-1:0] ST_NONE   = 2'd3;

  typedef enum logic [1:0] {
    SCAN_MIN,
    SCAN_NEXT,
    SCAN_ARR,
    SCAN_ARR_SKIP
  } scan_kind_e;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic       res_full;
    logic       res_none;
    logic       res_bad;
    logic       scan_init;
    logic       issue;
    scan_kind_e kind;
    logic       set_min;
    logic       jump;
    logic       take;
    logic       run;
    logic       fin;
    logic       wt;
    logic       sum;
    logic       out_load;
  } rrss_cmd_t;

  typedef struct packed {
    logic run_started;
    logic ring_empty;
    logic table_full;
    logic ev_busy;
    logic found;
    logic out_free;
  } rrss_sts_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PNUM_W-1:0] proc_number;
    logic [TIME_W-1:0] slice_start;
    logic [TIME_W-1:0] slice_end;
    logic              proc_finished;
    logic [TIME_W-1:0] first_start;
    logic [TIME_W-1:0] waiting_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [SUM_W-1:0]  total_waiting;
    logic [SUM_W-1:0]  total_turnaround;
  } rrss_res_t;

endpackage

### hw/rtl/rrss_ifs.sv
// Request, response and configuration channels of the slice scheduler.
// Depends on rrss_pkg for field widths.
interface rrss_req_if;
  logic                        valid;
  logic                        ready;
  logic [rrss_pkg::FUNC_W-1:0] func;
  logic [rrss_pkg::IN_W-1:0]   arrival_time;
  logic [rrss_pkg::IN_W-1:0]   burst_time;
  modport source (output valid, func, arrival_time, burst_time, input ready);
  modport sink (input valid, func, arrival_time, burst_time, output ready);
endinterface

interface rrss_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [rrss_pkg::STAT_W-1:0] status;
  logic [rrss_pkg::PNUM_W-1:0] proc_number;
  logic [rrss_pkg::TIME_W-1:0] slice_start;
  logic [rrss_pkg::TIME_W-1:0] slice_end;
  logic                        proc_finished;
  logic [rrss_pkg::TIME_W-1:0] first_start;
  logic [rrss_pkg::TIME_W-1:0] waiting_time;
  logic [rrss_pkg::TIME_W-1:0] turnaround_time;
  logic [rrss_pkg::SUM_W-1:0]  total_waiting;
  logic [rrss_pkg::SUM_W-1:0]  total_turnaround;
  modport source (output valid, status, proc_number, slice_start, slice_end, proc_finished,
                  first_start, waiting_time, turnaround_time, total_waiting,
                  total_turnaround, input ready);
  modport sink (input valid, status, proc_number, slice_start, slice_end, proc_finished,
                first_start, waiting_time, turnaround_time, total_waiting,
                total_turnaround, output ready);
endinterface

interface rrss_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [rrss_pkg::TQ_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### hw/rtl/rrss_datapath.sv
// Datapath: process tables, ready ring, time and sums, result and output registers.
// Depends on rrss_pkg and the assertion macros header.
`include "round_robin_slice_scheduler_defines.svh"
module rrss_datapath #(
  parameter int unsigned MAX_PROCS     = rrss_pkg::MAX_PROCS_DEF,
  parameter int unsigned DURATION_BITS = rrss_pkg::DUR_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rrss_pkg::rrss_cmd_t               cmd_i,
  input  logic [$clog2(MAX_PROCS)-1:0]      scan_addr_i,
  input  logic [rrss_pkg::IN_W-1:0]         arrival_i,
  input  logic [rrss_pkg::IN_W-1:0]         burst_i,
  input  logic                              cfg_valid_i,
  input  logic [rrss_pkg::TQ_W-1:0]         cfg_data_i,
  output rrss_pkg::rrss_sts_t               sts_o,
  output logic [$clog2(MAX_PROCS+1)-1:0]    loaded_o,
  output logic                              rsp_valid_o,
  input  logic                              rsp_ready_i,
  output rrss_pkg::rrss_res_t               rsp_data_o
);
  import rrss_pkg::*;

  localparam int unsigned IW   = $clog2(MAX_PROCS);
  localparam int unsigned CW   = $clog2(MAX_PROCS + 1);
  localparam int unsigned DW   = DURATION_BITS;
  localparam int unsigned CMPW = (DW > TIME_W) ? DW : TIME_W;
  localparam int unsigned RUNW = (DW > TQ_W) ? DW : TQ_W;

  logic [DW-1:0]     arr_mem [MAX_PROCS];
  logic [DW-1:0]     bur_mem [MAX_PROCS];
  logic [DW-1:0]     rem_mem [MAX_PROCS];
  logic [TIME_W-1:0] frs_mem [MAX_PROCS];
  logic [IW-1:0]     ring_mem [MAX_PROCS];

  logic [DW-1:0]     arr_rd_q, bur_rd_q, rem_rd_q;
  logic [TIME_W-1:0] frs_rd_q;
  logic [IW-1:0]     ring_rd_q;

  logic [TQ_W-1:0]      tq_q;
  logic [CW-1:0]        loaded_q, ring_cnt_q;
  logic [IW-1:0]        head_q, tail_q;
  logic [MAX_PROCS-1:0] queued_q, has_run_q;
  logic [TIME_W-1:0]    cur_q;
  logic                 started_q;
  logic [SUM_W-1:0]     wsum_q, tsum_q;
  logic                 ev_vld_q;
  logic [IW-1:0]        ev_idx_q;
  scan_kind_e           ev_kind_q;
  logic                 found_q;
  logic [DW-1:0]        min_q;
  logic [IW-1:0]        idx_q;
  logic [TIME_W-1:0]    start_q, fs_q;
  logic                 rem_left_q;
  logic [DW-1:0]        arr_q, bur_q;
  rrss_res_t            res_q, res_d, out_q;
  logic                 out_vld_q;

  logic [IW-1:0]     rd_addr, ld_idx, push_idx, head_nxt, tail_nxt;
  logic              take_min, ev_take, ev_hit, ring_room, scan_push, fin_push, push;
  logic [TQ_W-1:0]   quantum;
  logic [RUNW-1:0]   run_len;
  logic [DW-1:0]     rem_new;
  logic [TIME_W-1:0] cur_run, tat;
  logic [SUM_W-1:0]  wsum_nxt, tsum_nxt;
  logic [IW:0]       idx_num;
  logic [CW:0]       ld_num;

  assign rd_addr  = cmd_i.issue ? scan_addr_i : idx_q;
  assign ld_idx   = loaded_q[IW-1:0];
  assign head_nxt = (head_q == IW'(MAX_PROCS - 1)) ? '0 : head_q + 1'b1;
  assign tail_nxt = (tail_q == IW'(MAX_PROCS - 1)) ? '0 : tail_q + 1'b1;

  // scan evaluation, one entry per cycle behind the read address
  assign take_min = !found_q || (arr_rd_q < min_q);
  assign ev_hit   = !queued_q[ev_idx_q] && (rem_rd_q != '0) &&
                    (CMPW'(arr_rd_q) <= CMPW'(cur_q)) &&
                    !((ev_kind_q == SCAN_ARR_SKIP) && (ev_idx_q == idx_q));
  always_comb begin
    unique case (ev_kind_q)
      SCAN_MIN:  ev_take = take_min;
      SCAN_NEXT: ev_take = take_min && (rem_rd_q != '0);
      default:   ev_take = 1'b0;
    endcase
  end

  assign ring_room = (ring_cnt_q != CW'(MAX_PROCS));
  assign scan_push = ev_vld_q && ((ev_kind_q == SCAN_ARR) || (ev_kind_q == SCAN_ARR_SKIP)) &&
                     ev_hit && ring_room;
  assign fin_push  = cmd_i.fin && rem_left_q && ring_room;
  assign push      = scan_push || fin_push;
  assign push_idx  = cmd_i.fin ? idx_q : ev_idx_q;

  assign quantum  = (tq_q == '0) ? TQ_W'(1) : tq_q;
  assign run_len  = (RUNW'(rem_rd_q) < RUNW'(quantum)) ? RUNW'(rem_rd_q) : RUNW'(quantum);
  assign rem_new  = rem_rd_q - DW'(run_len);
  assign cur_run  = cur_q + TIME_W'(run_len);
  assign tat      = cur_q - TIME_W'(arr_q);
  assign wsum_nxt = res_q.proc_finished ? wsum_q + SUM_W'(res_q.waiting_time) : wsum_q;
  assign tsum_nxt = res_q.proc_finished ? tsum_q + SUM_W'(res_q.turnaround_time) : tsum_q;
  assign idx_num  = {1'b0, idx_q} + 1'b1;
  assign ld_num   = {1'b0, loaded_q} + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      arr_mem[ld_idx] <= DW'(arrival_i);
      bur_mem[ld_idx] <= DW'(burst_i);
    end
    if (cmd_i.load) begin
      rem_mem[ld_idx] <= DW'(burst_i);
    end else if (cmd_i.run) begin
      rem_mem[idx_q] <= rem_new;
    end
    if (cmd_i.run && !has_run_q[idx_q]) begin
      frs_mem[idx_q] <= cur_q;
    end
    if (push) begin
      ring_mem[tail_q] <= push_idx;
    end
    arr_rd_q  <= arr_mem[rd_addr];
    bur_rd_q  <= bur_mem[rd_addr];
    rem_rd_q  <= rem_mem[rd_addr];
    frs_rd_q  <= frs_mem[rd_addr];
    ring_rd_q <= ring_mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tq_q       <= TQ_W'(1);
      loaded_q   <= '0;
      ring_cnt_q <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      queued_q   <= '0;
      has_run_q  <= '0;
      cur_q      <= '0;
      started_q  <= 1'b0;
      wsum_q     <= '0;
      tsum_q     <= '0;
      ev_vld_q   <= 1'b0;
      ev_idx_q   <= '0;
      ev_kind_q  <= SCAN_MIN;
      found_q    <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        tq_q <= cfg_data_i;
      end
      ev_vld_q <= cmd_i.issue;
      if (cmd_i.issue) begin
        ev_idx_q  <= scan_addr_i;
        ev_kind_q <= cmd_i.kind;
      end
      if (cmd_i.scan_init) begin
        found_q <= 1'b0;
      end else if (ev_vld_q && ev_take) begin
        found_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cmd_i.clear) begin
        loaded_q   <= '0;
        ring_cnt_q <= '0;
        head_q     <= '0;
        tail_q     <= '0;
        queued_q   <= '0;
        has_run_q  <= '0;
        cur_q      <= '0;
        started_q  <= 1'b0;
        wsum_q     <= '0;
        tsum_q     <= '0;
      end else begin
        if (cmd_i.load) begin
          loaded_q          <= loaded_q + 1'b1;
          queued_q[ld_idx]  <= 1'b0;
          has_run_q[ld_idx] <= 1'b0;
        end
        if (push) begin
          tail_q             <= tail_nxt;
          ring_cnt_q         <= ring_cnt_q + 1'b1;
          queued_q[push_idx] <= 1'b1;
        end else if (cmd_i.take) begin
          head_q              <= head_nxt;
          ring_cnt_q          <= ring_cnt_q - 1'b1;
          queued_q[ring_rd_q] <= 1'b0;
        end
        if (cmd_i.set_min) begin
          cur_q     <= TIME_W'(min_q);
          started_q <= 1'b1;
        end else if (cmd_i.jump) begin
          if (CMPW'(cur_q) < CMPW'(min_q)) begin
            cur_q <= TIME_W'(min_q);
          end
        end else if (cmd_i.run) begin
          cur_q            <= cur_run;
          has_run_q[idx_q] <= 1'b1;
        end
        if (cmd_i.sum) begin
          wsum_q <= wsum_nxt;
          tsum_q <= tsum_nxt;
        end
      end
    end
  end

  always_comb begin
    res_d = res_q;
    priority if (cmd_i.clear || cmd_i.res_bad || cmd_i.res_full) begin
      res_d        = '0;
      res_d.status = cmd_i.clear ? ST_ACCEPT : (cmd_i.res_full ? ST_FULL : ST_NONE);
    end else if (cmd_i.load) begin
      res_d             = '0;
      res_d.status      = ST_ACCEPT;
      res_d.proc_number = PNUM_W'(ld_num);
    end else if (cmd_i.res_none) begin
      res_d                  = '0;
      res_d.status           = ST_NONE;
      res_d.total_waiting    = wsum_q;
      res_d.total_turnaround = tsum_q;
    end else if (cmd_i.fin) begin
      res_d               = '0;
      res_d.status        = ST_GRANT;
      res_d.proc_number   = PNUM_W'(idx_num);
      res_d.slice_start   = start_q;
      res_d.slice_end     = cur_q;
      res_d.proc_finished = !rem_left_q;
      if (!rem_left_q) begin
        res_d.first_start     = fs_q;
        res_d.turnaround_time = tat;
      end
    end else if (cmd_i.wt) begin
      if (res_q.proc_finished) begin
        res_d.waiting_time = res_q.turnaround_time - TIME_W'(bur_q);
      end
    end else if (cmd_i.sum) begin
      res_d.total_waiting    = wsum_nxt;
      res_d.total_turnaround = tsum_nxt;
    end else begin
      res_d = res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_vld_q && ev_take) begin
      min_q <= arr_rd_q;
    end
    if (cmd_i.take) begin
      idx_q <= ring_rd_q;
    end
    if (cmd_i.run) begin
      start_q    <= cur_q;
      arr_q      <= arr_rd_q;
      bur_q      <= bur_rd_q;
      rem_left_q <= (rem_new != '0);
      fs_q       <= has_run_q[idx_q] ? frs_rd_q : cur_q;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
    res_q <= res_d;
  end

  assign sts_o.run_started = started_q;
  assign sts_o.ring_empty  = (ring_cnt_q == '0);
  assign sts_o.table_full  = (loaded_q == CW'(MAX_PROCS));
  assign sts_o.ev_busy     = ev_vld_q;
  assign sts_o.found       = found_q;
  assign sts_o.out_free    = !out_vld_q || rsp_ready_i;
  assign loaded_o          = loaded_q;
  assign rsp_valid_o       = out_vld_q;
  assign rsp_data_o        = out_q;

  `RRSS_ASSERT(a_ring_cap, ring_cnt_q <= CW'(MAX_PROCS), "ready ring count above capacity")
  `RRSS_ASSERT(a_take_nonempty, !cmd_i.take || (ring_cnt_q != '0), "pop from empty ring")
  `RRSS_ASSERT_NEXT(a_run_marks, cmd_i.run, has_run_q[idx_q], "run did not mark process")

endmodule

### hw/rtl/rrss_ctrl.sv
// Controller: request decode and slice sequencing (scans, pop, run, finish).
// Depends on rrss_pkg.
module rrss_ctrl #(
  parameter int unsigned MAX_PROCS = rrss_pkg::MAX_PROCS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  input  logic [rrss_pkg::FUNC_W-1:0]      req_func_i,
  output logic                             req_ready_o,
  input  rrss_pkg::rrss_sts_t              sts_i,
  input  logic [$clog2(MAX_PROCS+1)-1:0]   loaded_i,
  output rrss_pkg::rrss_cmd_t              cmd_o,
  output logic [$clog2(MAX_PROCS)-1:0]     scan_addr_o
);
  import rrss_pkg::*;

  localparam int unsigned IW = $clog2(MAX_PROCS);
  localparam int unsigned CW = $clog2(MAX_PROCS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MIN  = 4'd1;
  localparam logic [3:0] S_ARR0 = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_NEXT = 4'd4;
  localparam logic [3:0] S_ARR1 = 4'd5;
  localparam logic [3:0] S_POP  = 4'd6;
  localparam logic [3:0] S_TAKE = 4'd7;
  localparam logic [3:0] S_RD   = 4'd8;
  localparam logic [3:0] S_RUN  = 4'd9;
  localparam logic [3:0] S_ARR2 = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;
  localparam logic [3:0] S_WT   = 4'd12;
  localparam logic [3:0] S_SUM  = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] scan_q, scan_d;
  logic          accept, scan_more, scan_done;

  assign accept      = req_valid_i && req_ready_o;
  assign req_ready_o = (state_q == S_IDLE);
  assign scan_more   = (scan_q != loaded_i);
  assign scan_done   = !scan_more && !sts_i.ev_busy;
  assign scan_addr_o = scan_q[IW-1:0];

  always_comb begin
    state_d = state_q;
    scan_d  = '0;
    cmd_o   = '0;
    // walk the table one entry per cycle in the scan states
    if ((state_q == S_MIN) || (state_q == S_NEXT) || (state_q == S_ARR0) ||
        (state_q == S_ARR1) || (state_q == S_ARR2)) begin
      cmd_o.issue = scan_more;
      scan_d      = scan_more ? scan_q + 1'b1 : scan_q;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_func_i)
            FN_CLEAR: begin
              cmd_o.clear = 1'b1;
              state_d     = S_OUT;
            end
            FN_LOAD: begin
              cmd_o.load     = !sts_i.table_full;
              cmd_o.res_full = sts_i.table_full;
              state_d        = S_OUT;
            end
            FN_SCHED: begin
              if (!sts_i.run_started && (loaded_i != '0)) begin
                cmd_o.scan_init = 1'b1;
                state_d         = S_MIN;
              end else begin
                state_d = S_CHK;
              end
            end
            default: begin
              cmd_o.res_bad = 1'b1;
              state_d       = S_OUT;
            end
          endcase
        end
      end
      S_MIN: begin
        cmd_o.kind = SCAN_MIN;
        if (scan_done) begin
          cmd_o.set_min = 1'b1;
          scan_d        = '0;
          state_d       = S_ARR0;
        end
      end
      S_ARR0: begin
        cmd_o.kind = SCAN_ARR;
        if (scan_done) begin
          scan_d  = '0;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.ring_empty) begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_NEXT;
        end else begin
          state_d = S_POP;
        end
      end
      S_NEXT: begin
        cmd_o.kind = SCAN_NEXT;
        if (scan_done) begin
          scan_d = '0;
          if (sts_i.found) begin
            cmd_o.jump = 1'b1;
            state_d    = S_ARR1;
          end else begin
            cmd_o.res_none = 1'b1;
            state_d        = S_OUT;
          end
        end
      end
      S_ARR1: begin
        cmd_o.kind = SCAN_ARR;
        if (scan_done) begin
          scan_d = '0;
          if (sts_i.ring_empty) begin
            cmd_o.res_none = 1'b1;
            state_d        = S_OUT;
          end else begin
            state_d = S_POP;
          end
        end
      end
      S_POP: state_d = S_TAKE;
      S_TAKE: begin
        cmd_o.take = 1'b1;
        state_d    = S_RD;
      end
      S_RD: state_d = S_RUN;
      S_RUN: begin
        cmd_o.run = 1'b1;
        state_d   = S_ARR2;
      end
      S_ARR2: begin
        cmd_o.kind = SCAN_ARR_SKIP;
        if (scan_done) begin
          scan_d  = '0;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_WT;
      end
      S_WT: begin
        cmd_o.wt = 1'b1;
        state_d  = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        // hold until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
    end
  end

endmodule

### hw/rtl/round_robin_slice_scheduler.sv
// Round-robin slice scheduler: top level, controller plus datapath.
// Depends on rrss_pkg, rrss_ifs, rrss_ctrl and rrss_datapath.
//
// Usage: every request on req_i returns exactly one response on rsp_o.
// func CLEAR empties the process table, LOAD appends one process (arrival,
// burst), SCHED grants one round-robin slice and reports its timing and the
// running sums, on completion also the process statistics, or reports none.
// cfg_i writes the time quantum; the user writes it only while the block is
// idle, which the block itself does not enforce. It is always ready. Reset sets
// the quantum to 1 and empties the table; the tables need no clearing pass.
// Walks: SCHED walks the loaded table through the single read port of the
// process tables. With work in the ring it walks once after the run. The
// first SCHED, or one that finds the ring empty, adds two walks. A first
// SCHED whose earliest process has zero burst walks five times. A SCHED
// with nothing left to run answers after one walk. CLEAR, LOAD and invalid
// codes go straight to the output step. One request is in work at a time.
// The response sits in an output register: a stalled receiver holds it, and
// the block still accepts and works on the next request meanwhile, waiting
// only to hand over its own response.
module round_robin_slice_scheduler #(
  parameter int unsigned MAX_PROCS     = rrss_pkg::MAX_PROCS_DEF,
  parameter int unsigned DURATION_BITS = rrss_pkg::DUR_BITS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  rrss_req_if.sink   req_i,
  rrss_rsp_if.source rsp_o,
  rrss_cfg_if.sink   cfg_i
);
  import rrss_pkg::*;

  rrss_cmd_t                      cmd;
  rrss_sts_t                      sts;
  rrss_res_t                      rsp_data;
  logic [$clog2(MAX_PROCS)-1:0]   scan_addr;
  logic [$clog2(MAX_PROCS+1)-1:0] loaded;

  assign cfg_i.ready = 1'b1;

  rrss_ctrl #(
    .MAX_PROCS(MAX_PROCS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_func_i (req_i.func),
    .req_ready_o(req_i.ready),
    .sts_i      (sts),
    .loaded_i   (loaded),
    .cmd_o      (cmd),
    .scan_addr_o(scan_addr)
  );

  rrss_datapath #(
    .MAX_PROCS    (MAX_PROCS),
    .DURATION_BITS(DURATION_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .scan_addr_i(scan_addr),
    .arrival_i  (req_i.arrival_time),
    .burst_i    (req_i.burst_time),
    .cfg_valid_i(cfg_i.valid),
    .cfg_data_i (cfg_i.data),
    .sts_o      (sts),
    .loaded_o   (loaded),
    .rsp_valid_o(rsp_o.valid),
    .rsp_ready_i(rsp_o.ready),
    .rsp_data_o (rsp_data)
  );

  assign rsp_o.status           = rsp_data.status;
  assign rsp_o.proc_number      = rsp_data.proc_number;
  assign rsp_o.slice_start      = rsp_data.slice_start;
  assign rsp_o.slice_end        = rsp_data.slice_end;
  assign rsp_o.proc_finished    = rsp_data.proc_finished;
  assign rsp_o.first_start      = rsp_data.first_start;
  assign rsp_o.waiting_time     = rsp_data.waiting_time;
  assign rsp_o.turnaround_time  = rsp_data.turnaround_time;
  assign rsp_o.total_waiting    = rsp_data.total_waiting;
  assign rsp_o.total_turnaround = rsp_data.total_turnaround;

endmodule

### bench/tb_top.sv
// Self-checking testbench for the round-robin slice scheduler.
// Depends on rrss_pkg, rrss_ifs and the scheduler RTL; drives requests, predicts
// every response and checks it field by field.
module tb_top;
  import rrss_pkg::*;

  localparam int NPROC = 16;
  localparam int LIMIT = 3000000;
  localparam int ITEMS = 1650;
  localparam logic [FUNC_W-1:0] FN_UNDEF = 2'd3;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [IN_W-1:0]   arr;
    logic [IN_W-1:0]   bur;
    bit                known;
    logic [STAT_W-1:0] stat;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  rrss_req_if req ();
  rrss_rsp_if rsp ();
  rrss_cfg_if cfg ();

  round_robin_slice_scheduler u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp),
    .cfg_i (cfg)
  );

  // scheduler state mirror
  logic [15:0] quantum;
  logic [15:0] arr_tab [NPROC];
  logic [15:0] bur_tab [NPROC];
  logic [15:0] rem_tab [NPROC];
  logic [20:0] first_tab [NPROC];
  bit          ran_tab [NPROC];
  bit          queued_tab [NPROC];
  int          ring [$];
  int          n_loaded;
  logic [20:0] now_t;
  bit          started;
  logic [24:0] wait_sum;
  logic [24:0] tat_sum;

  rrss_res_t expected_rsp [$];
  int        errors;
  int        grants;
  int        finishes;
  int        n_sent;
  longint    cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL round_robin_slice_scheduler");
      $finish;
    end
  end

  function automatic void clear_table();
    for (int i = 0; i < NPROC; i++) begin
      queued_tab[i] = 0;
      ran_tab[i]    = 0;
    end
    ring.delete();
    n_loaded = 0;
    now_t    = '0;
    started  = 0;
    wait_sum = '0;
    tat_sum  = '0;
  endfunction

  function automatic void enqueue_arrived(int skip);
    for (int i = 0; i < n_loaded; i++) begin
      if (i != skip && !queued_tab[i] && rem_tab[i] > 0 && 21'(arr_tab[i]) <= now_t) begin
        ring.push_back(i);
        queued_tab[i] = 1;
      end
    end
  endfunction

  function automatic rrss_res_t predict_slice();
    rrss_res_t r;
    int idx;
    logic [16:0] q, run;
    logic [20:0] earliest_arr, tat, wt;
    bit found;
    r = '0;
    if (!started && n_loaded > 0) begin
      earliest_arr = arr_tab[0];
      for (int i = 1; i < n_loaded; i++)
        if (arr_tab[i] < earliest_arr) earliest_arr = arr_tab[i];
      now_t   = earliest_arr;
      started = 1;
      enqueue_arrived(NPROC);
    end
    if (ring.size() == 0) begin
      found = 0;
      earliest_arr = '0;
      for (int i = 0; i < n_loaded; i++)
        if (rem_tab[i] > 0 && (!found || 21'(arr_tab[i]) < earliest_arr)) begin
          earliest_arr = arr_tab[i];
          found        = 1;
        end
      if (found) begin
        if (now_t < earliest_arr) now_t = earliest_arr;
        enqueue_arrived(NPROC);
      end
      if (ring.size() == 0) begin
        r.status           = ST_NONE;
        r.total_waiting    = wait_sum;
        r.total_turnaround = tat_sum;
        return r;
      end
    end
    idx = ring.pop_front();
    queued_tab[idx] = 0;
    if (!ran_tab[idx]) begin
      ran_tab[idx]   = 1;
      first_tab[idx] = now_t;
    end
    q   = (quantum == 0) ? 17'd1 : 17'(quantum);
    run = (17'(rem_tab[idx]) < q) ? 17'(rem_tab[idx]) : q;
    r.slice_start = now_t;
    now_t = now_t + 21'(run);
    rem_tab[idx] = rem_tab[idx] - 16'(run);
    enqueue_arrived(idx);
    r.status      = ST_GRANT;
    r.proc_number = 5'(idx + 1);
    r.slice_end   = now_t;
    if (rem_tab[idx] > 0) begin
      ring.push_back(idx);
      queued_tab[idx] = 1;
    end else begin
      tat = now_t - 21'(arr_tab[idx]);
      wt  = tat - 21'(bur_tab[idx]);
      wait_sum = wait_sum + 25'(wt);
      tat_sum  = tat_sum + 25'(tat);
      r.proc_finished   = 1'b1;
      r.first_start     = first_tab[idx];
      r.waiting_time    = wt;
      r.turnaround_time = tat;
    end
    r.total_waiting    = wait_sum;
    r.total_turnaround = tat_sum;
    return r;
  endfunction

  function automatic rrss_res_t predict_response(logic [1:0] fn, logic [15:0] a,
                                                 logic [15:0] b);
    rrss_res_t r;
    r = '0;
    case (fn)
      FN_CLEAR: begin
        clear_table();
        r.status = ST_ACCEPT;
      end
      FN_LOAD: begin
        if (n_loaded >= NPROC) begin
          r.status = ST_FULL;
        end else begin
          arr_tab[n_loaded]    = a;
          bur_tab[n_loaded]    = b;
          rem_tab[n_loaded]    = b;
          first_tab[n_loaded]  = '0;
          ran_tab[n_loaded]    = 0;
          queued_tab[n_loaded] = 0;
          n_loaded++;
          r.status      = ST_ACCEPT;
          r.proc_number = 5'(n_loaded);
        end
      end
      FN_SCHED: r = predict_slice();
      default:  r.status = ST_NONE;
    endcase
    return r;
  endfunction

  // valid stays high after a request; a random gap before the next request or an idle phase drops it
  task automatic send_request(logic [1:0] fn, logic [15:0] a, logic [15:0] b);
    rrss_res_t r;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid        <= 1'b1;
    req.func         <= fn;
    req.arrival_time <= a;
    req.burst_time   <= b;
    do @(posedge clk_i); while (!req.ready);
    n_sent++;
    r = predict_response(fn, a, b);
    expected_rsp.push_back(r);
  endtask

  task automatic write_quantum(logic [15:0] value);
    req.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    quantum = value;
  endtask

  // response side: random stall then accept and compare
  initial begin
    rrss_res_t got, want;
    int stall;
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp.valid);
      got = '{rsp.status, rsp.proc_number, rsp.slice_start, rsp.slice_end,
              rsp.proc_finished, rsp.first_start, rsp.waiting_time,
              rsp.turnaround_time, rsp.total_waiting, rsp.total_turnaround};
      if (expected_rsp.size() == 0) begin
        $error("response with nothing expected: status %0d", got.status);
        errors++;
      end else begin
        want = expected_rsp.pop_front();
        if (got.status == ST_GRANT) grants++;
        if (got.proc_finished) finishes++;
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); errors++; end
        if (got.proc_number !== want.proc_number) begin
          $error("proc_number exp %0d got %0d", want.proc_number, got.proc_number);
          errors++; end
        if (got.slice_start !== want.slice_start) begin
          $error("slice_start exp %0d got %0d", want.slice_start, got.slice_start);
          errors++; end
        if (got.slice_end !== want.slice_end) begin
          $error("slice_end exp %0d got %0d", want.slice_end, got.slice_end); errors++; end
        if (got.proc_finished !== want.proc_finished) begin
          $error("proc_finished exp %0d got %0d", want.proc_finished, got.proc_finished);
          errors++; end
        if (got.first_start !== want.first_start) begin
          $error("first_start exp %0d got %0d", want.first_start, got.first_start);
          errors++; end
        if (got.waiting_time !== want.waiting_time) begin
          $error("waiting_time exp %0d got %0d", want.waiting_time, got.waiting_time);
          errors++; end
        if (got.turnaround_time !== want.turnaround_time) begin
          $error("turnaround_time exp %0d got %0d", want.turnaround_time,
                 got.turnaround_time); errors++; end
        if (got.total_waiting !== want.total_waiting) begin
          $error("total_waiting exp %0d got %0d", want.total_waiting, got.total_waiting);
          errors++; end
        if (got.total_turnaround !== want.total_turnaround) begin
          $error("total_turnaround exp %0d got %0d", want.total_turnaround,
                 got.total_turnaround); errors++; end
      end
    end
  end

  stim_row_t directed [] = '{
    '{FN_SCHED, 16'd0,     16'd0,     1, ST_NONE},   // empty table
    '{FN_UNDEF, 16'hFFFF,  16'hFFFF,  1, ST_NONE},   // undefined code
    '{FN_LOAD,  16'd5,     16'd3,     1, ST_ACCEPT},
    '{FN_LOAD,  16'd0,     16'd0,     1, ST_ACCEPT}, // zero burst, never runs
    '{FN_LOAD,  16'hFFFF,  16'hFFFF,  1, ST_ACCEPT},
    '{FN_LOAD,  16'd2,     16'd1,     1, ST_ACCEPT},
    '{FN_SCHED, 16'd0,     16'd0,     0, ST_NONE},
    '{FN_SCHED, 16'd0,     16'd0,     0, ST_NONE},
    '{FN_LOAD,  16'd1,     16'd2,     0, ST_ACCEPT}, // load after start
    '{FN_SCHED, 16'd0,     16'd0,     0, ST_NONE},
    '{FN_SCHED, 16'd0,     16'd0,     0, ST_NONE},
    '{FN_SCHED, 16'd0,     16'd0,     0, ST_NONE},
    '{FN_SCHED, 16'd0,     16'd0,     0, ST_NONE},
    '{FN_SCHED, 16'd0,     16'd0,     0, ST_NONE},
    '{FN_CLEAR, 16'd0,     16'd0,     1, ST_ACCEPT}
  };

  task automatic run_directed();
    for (int i = 0; i < directed.size(); i++) begin
      send_request(directed[i].func, directed[i].arr, directed[i].bur);
      // check typed-in status against the prediction too
      if (directed[i].known && expected_rsp[$].status !== directed[i].stat) begin
        $error("status exp %0d got %0d", directed[i].stat, expected_rsp[$].status);
        errors++;
      end
    end
  endtask

  // one table: random loads (some overfill), then mostly slices until two responses report NONE
  task automatic run_workload(int nload, bit wide);
    logic [15:0] a, b;
    int idle_hits;
    for (int i = 0; i < nload; i++) begin
      a = wide ? 16'($urandom) : 16'($urandom_range(0, 60));
      case ($urandom_range(0, 9))
        0: b = 16'd0;
        // long bursts only where the quantum keeps the slice count small
        1: b = (quantum >= 16'd4096) ? 16'($urandom) : 16'($urandom_range(13, 64));
        default: b = 16'($urandom_range(1, 12));
      endcase
      send_request(FN_LOAD, a, b);
      if ($urandom_range(0, 5) == 0) send_request(FN_SCHED, '0, '0);
    end
    idle_hits = 0;
    while (idle_hits < 2) begin
      case ($urandom_range(0, 40))
        0: send_request(FN_UNDEF, 16'($urandom), 16'($urandom));
        1: send_request(FN_LOAD, 16'($urandom_range(0, 200)), 16'($urandom_range(1, 6)));
        default: send_request(FN_SCHED, 16'($urandom), 16'($urandom));
      endcase
      if (expected_rsp[$].status == ST_NONE) idle_hits++;
    end
    send_request(FN_CLEAR, '0, '0);
  endtask

  initial begin
    logic [15:0] q;
    rst_ni       = 1'b0;
    cycles       = 0;
    errors       = 0;
    grants       = 0;
    finishes     = 0;
    n_sent       = 0;
    req.valid = 1'b0; req.func = '0; req.arrival_time = '0; req.burst_time = '0;
    cfg.valid = 1'b0; cfg.data = '0;
    quantum = 16'd1;
    clear_table();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    write_quantum(16'hFFFF);
    run_workload(4, 1);
    write_quantum(16'd0);
    run_workload(6, 0);

    while (n_sent < ITEMS) begin
      case ($urandom_range(0, 4))
        0: q = 16'd1;
        1: q = 16'($urandom_range(0, 4));
        2: q = 16'hFFFF;
        default: q = 16'($urandom_range(1, 20));
      endcase
      write_quantum(q);
      run_workload($urandom_range(1, 18), $urandom_range(0, 7) == 0);
    end

    req.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("covered %0d requests, %0d slices, %0d completions, quanta 0 through 65535",
             n_sent, grants, finishes);
    if (errors == 0) begin
      $display("PASS round_robin_slice_scheduler");
    end else begin
      $display("FAIL round_robin_slice_scheduler");
    end
    $finish;
  end
endmodule
